FILE: hdl/cffp_pkg.sv
// ---------------------------------------------------------------------------
// cffp_pkg
// Shared widths, types and codes of the calorimeter front face projection.
// ---------------------------------------------------------------------------
`default_nettype none

package cffp_pkg;

  localparam int CW  = 31;        // config register width
  localparam int MW  = 68;        // multiplier operand width, signed
  localparam int DW  = MW / 2;    // multiplier digit width
  localparam int PW  = 2 * MW;    // multiplier product width, signed
  localparam int ML  = 4;         // multiplier latency
  localparam int SQ  = 64;        // square root result bits, one per stage
  localparam int SRW = SQ + 3;    // square root remainder width
  localparam int DQ  = 33;        // quotient bits below the overflow point
  localparam int NW  = 100;       // divider numerator width
  localparam int DNW = 66;        // divider denominator width
  localparam int DRW = NW - DQ;   // divider remainder width
  localparam int LIMW = 95;       // width of endcap_z * a
  localparam int LAT = 121;       // total latency, input item to result item

  typedef logic signed [MW-1:0] mop_t;
  typedef logic signed [PW-1:0] prod_t;

  typedef enum logic [1:0] {
    REG_NONE      = 2'd0,
    REG_ENDCAP    = 2'd1,
    REG_BARREL_HI = 2'd2,
    REG_BARREL_LO = 2'd3
  } region_t;

  // per-item context that rides along the pipeline
  typedef struct packed {
    logic signed [31:0] px;
    logic signed [31:0] py;
    logic signed [31:0] pz;
    logic signed [31:0] dx;
    logic signed [31:0] dy;
    logic signed [31:0] dz;
    logic signed [33:0] tn0;
    logic [31:0]        td0;
    logic               e_ok;
    logic [63:0]        a;
    logic signed [64:0] b;
    logic               b_ok;
    logic [LIMW-1:0]    lim;
  } ctx_t;

endpackage

`default_nettype wire

FILE: hdl/cffp_mul.sv
// ---------------------------------------------------------------------------
// cffp_mul
// Pipelined signed multiplier: magnitudes split into two digits, four
// partial products, sum, then sign restore.
// ---------------------------------------------------------------------------
`default_nettype none

module cffp_mul import cffp_pkg::*; (
  input  logic  clk,
  input  logic  en,
  input  mop_t  x,
  input  mop_t  y,
  output prod_t p
);

  logic [MW-1:0]   xm, ym;
  logic            sg1, sg2, sg3;
  logic [2*DW-1:0] pp [4];
  logic [PW-1:0]   sum;

  always_ff @(posedge clk) begin
    if (en) begin
      xm     <= x[MW-1] ? MW'(-x) : MW'(x);
      ym     <= y[MW-1] ? MW'(-y) : MW'(y);
      sg1    <= x[MW-1] ^ y[MW-1];
      pp[0]  <= xm[DW-1:0]  * ym[DW-1:0];
      pp[1]  <= xm[DW-1:0]  * ym[MW-1:DW];
      pp[2]  <= xm[MW-1:DW] * ym[DW-1:0];
      pp[3]  <= xm[MW-1:DW] * ym[MW-1:DW];
      sg2    <= sg1;
      sum    <= PW'(pp[0]) + (PW'(pp[1]) << DW) + (PW'(pp[2]) << DW)
                + (PW'(pp[3]) << (2 * DW));
      sg3    <= sg2;
      p      <= sg3 ? -$signed(sum) : $signed(sum);
    end
  end

endmodule

`default_nettype wire

FILE: hdl/cffp_sqrt.sv
// ---------------------------------------------------------------------------
// cffp_sqrt
// Floor square root of a 128-bit value, one result bit per stage, with the
// item context carried alongside.
// ---------------------------------------------------------------------------
`default_nettype none

module cffp_sqrt import cffp_pkg::*; (
  input  logic          clk,
  input  logic          en,
  input  logic [2*SQ-1:0] v,
  input  ctx_t          ctx_in,
  output logic [SQ-1:0] root_out,
  output ctx_t          ctx_out
);

  logic [SRW-1:0]  rem  [SQ+1];
  logic [SQ-1:0]   root [SQ+1];
  logic [2*SQ-1:0] rad  [SQ+1];
  ctx_t            cx   [SQ+1];

  assign rem[0]  = '0;
  assign root[0] = '0;
  assign rad[0]  = v;
  assign cx[0]   = ctx_in;

  for (genvar i = 0; i < SQ; i++) begin : g_st
    localparam int SH = 2 * (SQ - 1 - i);
    logic [SRW-1:0] rs, tr;
    logic           ge;

    assign rs = {rem[i][SRW-3:0], rad[i][SH+1:SH]};
    assign tr = SRW'({root[i], 2'b01});
    assign ge = rs >= tr;

    always_ff @(posedge clk) begin
      if (en) begin
        rem[i+1]  <= ge ? rs - tr : rs;
        root[i+1] <= {root[i][SQ-2:0], ge};
        rad[i+1]  <= rad[i];
        cx[i+1]   <= cx[i];
      end
    end
  end

  assign root_out = root[SQ];
  assign ctx_out  = cx[SQ];

endmodule

`default_nettype wire

FILE: hdl/cffp_div.sv
// ---------------------------------------------------------------------------
// cffp_div
// Pipelined restoring divider: an overflow check for quotients of 2^DQ and
// up, then one quotient bit per stage.
// ---------------------------------------------------------------------------
`default_nettype none

module cffp_div import cffp_pkg::*; (
  input  logic           clk,
  input  logic           en,
  input  logic [NW-1:0]  num,
  input  logic [DNW-1:0] den,
  output logic [DQ-1:0]  q_out,
  output logic           ovf_out
);

  logic [DRW-1:0] r  [DQ+1];
  logic [DQ-1:0]  lo [DQ+1];
  logic [DNW-1:0] dn [DQ+1];
  logic [DQ-1:0]  q  [DQ+1];
  logic           ov [DQ+1];

  always_ff @(posedge clk) begin
    if (en) begin
      r[0]  <= num[NW-1:DQ];
      ov[0] <= num[NW-1:DQ] >= DRW'(den);
      lo[0] <= num[DQ-1:0];
      dn[0] <= den;
      q[0]  <= '0;
    end
  end

  for (genvar j = 0; j < DQ; j++) begin : g_st
    localparam int K = DQ - 1 - j;
    logic [DRW-1:0] rs;
    logic           ge;

    assign rs = {r[j][DRW-2:0], lo[j][K]};
    assign ge = rs >= DRW'(dn[j]);

    always_ff @(posedge clk) begin
      if (en) begin
        r[j+1]  <= ge ? rs - DRW'(dn[j]) : rs;
        q[j+1]  <= {q[j][DQ-2:0], ge};
        lo[j+1] <= lo[j];
        dn[j+1] <= dn[j];
        ov[j+1] <= ov[j];
      end
    end
  end

  assign q_out   = q[DQ];
  assign ovf_out = ov[DQ];

endmodule

`default_nettype wire

FILE: hdl/calorimeter_front_face_projection.sv
// ---------------------------------------------------------------------------
// calorimeter_front_face_projection
// Projects a point along a direction onto the barrel cylinder or the endcap
// plane, returning the nearest valid hit.
// ---------------------------------------------------------------------------
// Throughput: one item per cycle; the pipeline holds as a whole while the
// output register waits on m_tready.
// The long stretches are the 64-stage square root and the 34-stage dividers.
// Reset clears valid bits and both config registers (to zero).
`default_nettype none

module calorimeter_front_face_projection import cffp_pkg::*; (
  input  logic           clk,
  input  logic           rst,
  input  logic           cfg_we,
  input  logic           cfg_index,
  input  logic [CW-1:0]  cfg_data,
  input  logic           s_tvalid,
  output logic           s_tready,
  input  logic [191:0]   s_tdata,   // point_x, point_y, point_z, dir_x, dir_y, dir_z
  output logic           m_tvalid,
  input  logic           m_tready,
  output logic [95:0]    m_tdata,   // proj_x, proj_y, proj_z
  output logic [1:0]     m_tuser    // region
);

  localparam logic CFG_RADIUS = 1'b0;
  localparam logic CFG_ENDCAP = 1'b1;

  typedef struct packed {
    logic signed [65:0] tn1;
    logic signed [65:0] tn2;
    logic [64:0]        at1;
    logic [64:0]        at2;
  } root_t;

  typedef struct packed {
    logic [63:0] td;
    region_t     region;
  } sel_t;

  typedef struct packed {
    logic [2:0] neg;
    region_t    region;
  } tail_t;

  logic            en;
  logic [LAT-1:0]  vld;
  logic [CW-1:0]   radius, zcap;

  assign en       = !m_tvalid || m_tready;
  assign s_tready = en;
  assign m_tvalid = vld[LAT-1];

  always_ff @(posedge clk) begin
    if (rst) begin
      vld    <= '0;
      radius <= '0;
      zcap   <= '0;
    end else begin
      if (en) vld <= {vld[LAT-2:0], s_tvalid};
      if (cfg_we) begin
        case (cfg_index)
          CFG_RADIUS: radius <= cfg_data;
          CFG_ENDCAP: zcap   <= cfg_data;
          default: ;
        endcase
      end
    end
  end

  // ---- input stage: endcap parameter tn0/td0
  logic signed [31:0] in_pz, in_dz;
  logic signed [33:0] zp, nz;
  ctx_t               c0, c0_next;

  assign in_pz = s_tdata[95:64];
  assign in_dz = s_tdata[191:160];
  assign zp    = in_pz < 0 ? -$signed({3'b0, zcap}) : $signed({3'b0, zcap});
  assign nz    = zp - 34'(in_pz);

  always_comb begin
    c0_next      = '0;
    c0_next.px   = s_tdata[31:0];
    c0_next.py   = s_tdata[63:32];
    c0_next.pz   = in_pz;
    c0_next.dx   = s_tdata[127:96];
    c0_next.dy   = s_tdata[159:128];
    c0_next.dz   = in_dz;
    c0_next.tn0  = in_dz < 0 ? -nz : nz;
    c0_next.td0  = in_dz < 0 ? 32'(-in_dz) : 32'(in_dz);
    c0_next.e_ok = in_dz != 0;
  end

  always_ff @(posedge clk) begin
    if (en) c0 <= c0_next;
  end

  // ---- round 1 products
  mop_t  m1a [12], m1b [12];
  prod_t m1p [12];
  ctx_t  c1d [ML];

  always_comb begin
    m1a[0]  = MW'(c0.dx);              m1b[0]  = MW'(c0.dx);
    m1a[1]  = MW'(c0.dy);              m1b[1]  = MW'(c0.dy);
    m1a[2]  = MW'(c0.px);              m1b[2]  = MW'(c0.dx);
    m1a[3]  = MW'(c0.py);              m1b[3]  = MW'(c0.dy);
    m1a[4]  = MW'(c0.px);              m1b[4]  = MW'(c0.px);
    m1a[5]  = MW'(c0.py);              m1b[5]  = MW'(c0.py);
    m1a[6]  = MW'({1'b0, radius});     m1b[6]  = MW'({1'b0, radius});
    m1a[7]  = MW'({1'b0, c0.td0});     m1b[7]  = MW'({1'b0, c0.td0});
    m1a[8]  = MW'(c0.px);              m1b[8]  = MW'({1'b0, c0.td0});
    m1a[9]  = MW'(c0.dx);              m1b[9]  = MW'(c0.tn0);
    m1a[10] = MW'(c0.py);              m1b[10] = MW'({1'b0, c0.td0});
    m1a[11] = MW'(c0.dy);              m1b[11] = MW'(c0.tn0);
  end

  for (genvar g = 0; g < 12; g++) begin : g_m1
    cffp_mul u_mul (.clk(clk), .en(en), .x(m1a[g]), .y(m1b[g]), .p(m1p[g]));
  end

  always_ff @(posedge clk) begin
    if (en) begin
      c1d[0] <= c0;
      for (int i = 1; i < ML; i++) c1d[i] <= c1d[i-1];
    end
  end

  // ---- stage 2: a, b, c, endcap X and Y
  ctx_t               c2, c2_next;
  logic signed [65:0] cc2, x2, y2;
  logic [61:0]        rr2;
  logic [63:0]        tdsq2;

  always_comb begin
    c2_next   = c1d[ML-1];
    c2_next.a = 64'(m1p[0] + m1p[1]);
    c2_next.b = 65'(m1p[2] + m1p[3]);
  end

  always_ff @(posedge clk) begin
    if (en) begin
      c2    <= c2_next;
      cc2   <= 66'(m1p[4] + m1p[5] - m1p[6]);
      x2    <= 66'(m1p[8] + m1p[9]);
      y2    <= 66'(m1p[10] + m1p[11]);
      rr2   <= 62'(m1p[6]);
      tdsq2 <= 64'(m1p[7]);
    end
  end

  // ---- round 2 products
  mop_t  m2a [6], m2b [6];
  prod_t m2p [6];
  ctx_t  c3d [ML];

  always_comb begin
    m2a[0] = MW'(c2.b);            m2b[0] = MW'(c2.b);
    m2a[1] = MW'({1'b0, c2.a});    m2b[1] = MW'(cc2);
    m2a[2] = MW'(x2);              m2b[2] = MW'(x2);
    m2a[3] = MW'(y2);              m2b[3] = MW'(y2);
    m2a[4] = MW'({1'b0, rr2});     m2b[4] = MW'({1'b0, tdsq2});
    m2a[5] = MW'({1'b0, zcap});    m2b[5] = MW'({1'b0, c2.a});
  end

  for (genvar g = 0; g < 6; g++) begin : g_m2
    cffp_mul u_mul (.clk(clk), .en(en), .x(m2a[g]), .y(m2b[g]), .p(m2p[g]));
  end

  always_ff @(posedge clk) begin
    if (en) begin
      c3d[0] <= c2;
      for (int i = 1; i < ML; i++) c3d[i] <= c3d[i-1];
    end
  end

  // ---- stage 4: discriminant, endcap radius test
  prod_t          disc;
  ctx_t           c4, c4_next;
  logic [2*SQ-1:0] disc4;

  assign disc = m2p[0] - m2p[1];

  always_comb begin
    c4_next      = c3d[ML-1];
    c4_next.e_ok = c3d[ML-1].e_ok && ((m2p[2] + m2p[3]) <= m2p[4]);
    c4_next.b_ok = (c3d[ML-1].a != '0) && !disc[PW-1];
    c4_next.lim  = LIMW'(m2p[5]);
  end

  always_ff @(posedge clk) begin
    if (en) begin
      c4      <= c4_next;
      disc4   <= disc[2*SQ-1:0];
    end
  end

  // ---- square root
  logic [SQ-1:0] root5;
  ctx_t          c5;

  cffp_sqrt u_sqrt (
    .clk(clk), .en(en), .v(disc4), .ctx_in(c4), .root_out(root5), .ctx_out(c5)
  );

  // ---- stage 6: barrel roots
  logic signed [65:0] tp, tm;
  logic               plus_hi;
  ctx_t               c6;
  root_t              r6;
  logic [32:0]        at0_6;

  assign tp      = -66'(c5.b) + $signed({2'b0, root5});
  assign tm      = -66'(c5.b) - $signed({2'b0, root5});
  assign plus_hi = (c5.dx > 0) || (c5.dx == 0 && c5.dy > 0);

  always_ff @(posedge clk) begin
    if (en) begin
      c6     <= c5;
      r6.tn1 <= plus_hi ? tp : tm;
      r6.tn2 <= plus_hi ? tm : tp;
      r6.at1 <= plus_hi ? (tp[65] ? 65'(-tp) : 65'(tp)) : (tm[65] ? 65'(-tm) : 65'(tm));
      r6.at2 <= plus_hi ? (tm[65] ? 65'(-tm) : 65'(tm)) : (tp[65] ? 65'(-tp) : 65'(tp));
      at0_6  <= c5.tn0[33] ? 33'(-c5.tn0) : 33'(c5.tn0);
    end
  end

  // ---- round 3 products: barrel z and nearness cross terms
  mop_t  m3a [6], m3b [6];
  prod_t m3p [6];
  ctx_t  c7d [ML];
  root_t r7d [ML];

  always_comb begin
    m3a[0] = MW'(c6.pz);            m3b[0] = MW'({1'b0, c6.a});
    m3a[1] = MW'(c6.dz);            m3b[1] = MW'(r6.tn1);
    m3a[2] = MW'(c6.dz);            m3b[2] = MW'(r6.tn2);
    m3a[3] = MW'({1'b0, at0_6});    m3b[3] = MW'({1'b0, c6.a});
    m3a[4] = MW'({1'b0, r6.at1});   m3b[4] = MW'({1'b0, c6.td0});
    m3a[5] = MW'({1'b0, r6.at2});   m3b[5] = MW'({1'b0, c6.td0});
  end

  for (genvar g = 0; g < 6; g++) begin : g_m3
    cffp_mul u_mul (.clk(clk), .en(en), .x(m3a[g]), .y(m3b[g]), .p(m3p[g]));
  end

  always_ff @(posedge clk) begin
    if (en) begin
      c7d[0] <= c6;
      r7d[0] <= r6;
      for (int i = 1; i < ML; i++) begin
        c7d[i] <= c7d[i-1];
        r7d[i] <= r7d[i-1];
      end
    end
  end

  // ---- stage 8: barrel z test and nearest candidate
  ctx_t               c7;
  root_t              r7;
  prod_t              z1, z2, az1, az2;
  logic               ok1, ok2;
  region_t            best;
  logic signed [65:0] sel_tn;
  logic [63:0]        sel_td;

  assign c7  = c7d[ML-1];
  assign r7  = r7d[ML-1];
  assign z1  = m3p[0] + m3p[1];
  assign z2  = m3p[0] + m3p[2];
  assign az1 = z1[PW-1] ? -z1 : z1;
  assign az2 = z2[PW-1] ? -z2 : z2;
  assign ok1 = c7.b_ok && (az1 <= $signed(PW'(c7.lim)));
  assign ok2 = c7.b_ok && (az2 <= $signed(PW'(c7.lim)));

  always_comb begin
    best = c7.e_ok ? REG_ENDCAP : REG_NONE;
    if (ok1) begin
      if (best == REG_NONE || m3p[4] < m3p[3]) best = REG_BARREL_HI;
    end
    if (ok2) begin
      case (best)
        REG_NONE:      best = REG_BARREL_LO;
        REG_ENDCAP:    if (m3p[5] < m3p[3]) best = REG_BARREL_LO;
        REG_BARREL_HI: if (r7.at2 < r7.at1) best = REG_BARREL_LO;
        default: ;
      endcase
    end
    case (best)
      REG_BARREL_HI: begin sel_tn = r7.tn1;       sel_td = c7.a; end
      REG_BARREL_LO: begin sel_tn = r7.tn2;       sel_td = c7.a; end
      default:       begin sel_tn = 66'(c7.tn0);  sel_td = 64'(c7.td0); end
    endcase
  end

  ctx_t               c8;
  logic signed [65:0] tn8;
  sel_t               s8;

  always_ff @(posedge clk) begin
    if (en) begin
      c8        <= c7;
      tn8       <= sel_tn;
      s8.td     <= sel_td;
      s8.region <= best;
    end
  end

  // ---- round 4 products: coordinate numerators
  mop_t  m4a [6], m4b [6];
  prod_t m4p [6];
  sel_t  s9d [ML];

  always_comb begin
    m4a[0] = MW'(c8.px);  m4b[0] = MW'({1'b0, s8.td});
    m4a[1] = MW'(c8.dx);  m4b[1] = MW'(tn8);
    m4a[2] = MW'(c8.py);  m4b[2] = MW'({1'b0, s8.td});
    m4a[3] = MW'(c8.dy);  m4b[3] = MW'(tn8);
    m4a[4] = MW'(c8.pz);  m4b[4] = MW'({1'b0, s8.td});
    m4a[5] = MW'(c8.dz);  m4b[5] = MW'(tn8);
  end

  for (genvar g = 0; g < 6; g++) begin : g_m4
    cffp_mul u_mul (.clk(clk), .en(en), .x(m4a[g]), .y(m4b[g]), .p(m4p[g]));
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s9d[0] <= s8;
      for (int i = 1; i < ML; i++) s9d[i] <= s9d[i-1];
    end
  end

  // ---- stage 10: rounding divide operands, 2|num|+td over 2td
  prod_t          num9 [3];
  prod_t          mag9 [3];
  logic [NW-1:0]  n10  [3];
  logic [DNW-1:0] d10;
  tail_t          t10;

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      num9[k] = m4p[2*k] + m4p[2*k+1];
      mag9[k] = num9[k][PW-1] ? -num9[k] : num9[k];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int k = 0; k < 3; k++) begin
        n10[k]     <= {mag9[k][NW-2:0], 1'b0} + NW'(s9d[ML-1].td);
        t10.neg[k] <= num9[k][PW-1];
      end
      d10        <= DNW'({s9d[ML-1].td, 1'b0});
      t10.region <= s9d[ML-1].region;
    end
  end

  // ---- dividers
  logic [DQ-1:0] q   [3];
  logic          ovf [3];
  tail_t         tdl [DQ+1];

  for (genvar g = 0; g < 3; g++) begin : g_div
    cffp_div u_div (
      .clk(clk), .en(en), .num(n10[g]), .den(d10), .q_out(q[g]), .ovf_out(ovf[g])
    );
  end

  always_ff @(posedge clk) begin
    if (en) begin
      tdl[0] <= t10;
      for (int i = 1; i <= DQ; i++) tdl[i] <= tdl[i-1];
    end
  end

  // ---- output register: sign, saturate, blank on no hit
  logic [31:0] res [3];

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      if (tdl[DQ].region == REG_NONE) begin
        res[k] = '0;
      end else if (!tdl[DQ].neg[k]) begin
        res[k] = (ovf[k] || q[k] > DQ'(32'h7fff_ffff)) ? 32'h7fff_ffff : q[k][31:0];
      end else begin
        res[k] = (ovf[k] || q[k] > DQ'(32'h8000_0000)) ? 32'h8000_0000 : 32'(-q[k]);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      m_tdata <= {res[2], res[1], res[0]};
      m_tuser <= tdl[DQ].region;
    end
  end

endmodule

`default_nettype wire

FILE: hdl/cffp_checker.sv
// ---------------------------------------------------------------------------
// cffp_checker
// Port-level checks of the projection block, bound to the top level.
// ---------------------------------------------------------------------------
`default_nettype none

module cffp_checker import cffp_pkg::*; (
  input logic         clk,
  input logic         rst,
  input logic         s_tready,
  input logic         m_tvalid,
  input logic         m_tready,
  input logic [95:0]  m_tdata,
  input logic [1:0]   m_tuser
);

  // a held result stays put
  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
    else $error("result changed while stalled");

  // an empty output register never blocks the input
  a_ready: assert property (@(posedge clk) disable iff (rst)
    !m_tvalid |-> s_tready)
    else $error("input stalled with empty output");

  // no hit gives zero coordinates
  a_miss: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tuser == REG_NONE |-> m_tdata == '0)
    else $error("nonzero coordinates on a miss");

  // reset drains the pipeline
  a_rst: assert property (@(posedge clk) rst |=> !m_tvalid)
    else $error("result valid right after reset");

endmodule

bind calorimeter_front_face_projection cffp_checker u_chk (.*);

`default_nettype wire

FILE: bench/calorimeter_front_face_projection_tb.sv
// ---------------------------------------------------------------------------
// calorimeter_front_face_projection_tb
// Sends point/direction items through the projection block. Each expected
// hit is computed exactly with wide integer arithmetic and queued. Every
// result is then checked field by field against the oldest queued hit.
// Both stream sides stall at random.
// ---------------------------------------------------------------------------
`default_nettype none

module calorimeter_front_face_projection_tb;
  import cffp_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  typedef logic signed [191:0] wint_t;

  typedef struct {
    logic signed [31:0] x;
    logic signed [31:0] y;
    logic signed [31:0] z;
    region_t            rg;
  } hit_t;

  localparam logic IDX_RADIUS = 1'b0;
  localparam logic IDX_ENDCAP = 1'b1;
  localparam logic [30:0] CFG_MAX = 31'h7fffffff;

  logic          clk = 1'b0;
  logic          rst = 1'b1;
  logic          cfg_we = 1'b0;
  logic          cfg_index = 1'b0;
  logic [CW-1:0] cfg_data = '0;
  logic          s_tvalid = 1'b0;
  logic          s_tready;
  logic [191:0]  s_tdata = '0;   // point_x, point_y, point_z, dir_x, dir_y, dir_z
  logic          m_tvalid;
  logic          m_tready = 1'b0;
  logic [95:0]   m_tdata;        // proj_x, proj_y, proj_z
  logic [1:0]    m_tuser;        // region

  // register copies used for prediction
  logic [30:0] radius_q = '0;
  logic [30:0] endcap_q = '0;

  hit_t expected_hits[$];
  int   mismatches = 0;
  bit   no_idle = 1'b0;
  int   stall_left = 0;

  calorimeter_front_face_projection u_dut (
    .clk(clk), .rst(rst),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  initial begin
    #2ms;
    $display("Some tests failed");
    $finish;
  end

  function automatic wint_t wabs(input wint_t v);
    return v < 0 ? -v : v;
  endfunction

  function automatic wint_t isqrt(input wint_t v);
    wint_t r;
    wint_t c;
    wint_t one;
    r = 0;
    one = 1;
    for (int k = 64; k >= 0; k--) begin
      c = r | (one << k);
      if (c * c <= v) r = c;
    end
    return r;
  endfunction

  // round half away from zero, then clamp to 32 bits
  function automatic logic [31:0] round_sat(input wint_t num, input wint_t den);
    wint_t q;
    wint_t qmax;
    wint_t qmin;
    qmax = 32'sh7fffffff;
    qmin = 32'sh80000000;
    q = (2 * wabs(num) + den) / (2 * den);
    if (num < 0) q = -q;
    if (q > qmax) q = qmax;
    if (q < qmin) q = qmin;
    return q[31:0];
  endfunction

  function automatic hit_t project_hit(input logic signed [31:0] px, py, pz, dx, dy, dz);
    wint_t wpx, wpy, wpz, wdx, wdy, wdz, rr, zz;
    wint_t tn[3];
    wint_t td[3];
    bit    ok[3];
    wint_t n, xs, ys, a, b, c, disc, s, lim, zc;
    bit    plus_larger;
    int    best;
    hit_t  h;
    wpx = px; wpy = py; wpz = pz; wdx = dx; wdy = dy; wdz = dz;
    rr = {1'b0, radius_q};
    zz = {1'b0, endcap_q};
    ok = '{0, 0, 0};
    tn = '{0, 0, 0};
    td = '{1, 1, 1};
    if (dz != 0) begin
      n = (pz < 0 ? -zz : zz) - wpz;
      tn[0] = dz < 0 ? -n : n;
      td[0] = wabs(wdz);
      xs = wpx * td[0] + wdx * tn[0];
      ys = wpy * td[0] + wdy * tn[0];
      ok[0] = xs * xs + ys * ys <= rr * rr * td[0] * td[0];
    end
    a = wdx * wdx + wdy * wdy;
    if (a != 0) begin
      b = wpx * wdx + wpy * wdy;
      c = wpx * wpx + wpy * wpy - rr * rr;
      disc = b * b - a * c;
      if (disc >= 0) begin
        s = isqrt(disc);
        plus_larger = dx > 0 || (dx == 0 && dy > 0);
        tn[1] = plus_larger ? -b + s : -b - s;
        tn[2] = plus_larger ? -b - s : -b + s;
        lim = zz * a;
        for (int k = 1; k < 3; k++) begin
          td[k] = a;
          zc = wpz * a + wdz * tn[k];
          ok[k] = wabs(zc) <= lim;
        end
      end
    end
    best = -1;
    for (int k = 0; k < 3; k++) begin
      if (ok[k] && (best < 0 || wabs(tn[k]) * td[best] < wabs(tn[best]) * td[k])) best = k;
    end
    if (best < 0) begin
      h.x = 0; h.y = 0; h.z = 0; h.rg = REG_NONE;
    end else begin
      h.x = round_sat(wpx * td[best] + wdx * tn[best], td[best]);
      h.y = round_sat(wpy * td[best] + wdy * tn[best], td[best]);
      h.z = round_sat(wpz * td[best] + wdz * tn[best], td[best]);
      h.rg = region_t'(best + 1);
    end
    return h;
  endfunction

  task automatic send_ray(input logic signed [31:0] px, py, pz, dx, dy, dz);
    int gap;
    gap = no_idle ? 0 : $urandom_range(0, 18);
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata <= {dz, dy, dx, pz, py, px};
    expected_hits.push_back(project_hit(px, py, pz, dx, dy, dz));
    @(posedge clk);
    while (!s_tready) @(posedge clk);
  endtask

  task automatic drain_and_set(input logic [30:0] radius, input logic [30:0] zplane);
    s_tvalid <= 1'b0;
    while (expected_hits.size() > 0) @(posedge clk);
    repeat (LAT + 4) @(posedge clk);
    cfg_we <= 1'b1; cfg_index <= IDX_RADIUS; cfg_data <= radius;
    @(posedge clk);
    cfg_index <= IDX_ENDCAP; cfg_data <= zplane;
    @(posedge clk);
    cfg_we <= 1'b0;
    radius_q = radius;
    endcap_q = zplane;
  endtask

  // coordinate within +-span, mostly; sometimes full range
  function automatic logic signed [31:0] coord_near(input int unsigned span);
    if ($urandom_range(0, 15) == 0) return $urandom;
    return $signed($urandom_range(0, 2 * span)) - $signed(span);
  endfunction

  // responder: hold m_tready low for a random count after each item
  always @(posedge clk) begin
    if (rst) begin
      m_tready <= 1'b0;
      stall_left = 0;
    end else if (m_tvalid && m_tready) begin
      stall_left = no_idle ? 0 : $urandom_range(0, 18);
      if (stall_left > 0) m_tready <= 1'b0;
    end else if (!m_tready) begin
      if (stall_left > 0) stall_left--;
      if (stall_left == 0) m_tready <= 1'b1;
    end
  end

  always @(posedge clk) begin
    hit_t e;
    if (!rst && m_tvalid && m_tready) begin
      if (expected_hits.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result x=%0d y=%0d z=%0d region=%0d",
          $signed(m_tdata[31:0]), $signed(m_tdata[63:32]), $signed(m_tdata[95:64]), m_tuser);
      end else begin
        e = expected_hits.pop_front();
        if (m_tdata[31:0] !== e.x || m_tdata[63:32] !== e.y || m_tdata[95:64] !== e.z ||
            m_tuser !== e.rg) begin
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch: exp x=%0d y=%0d z=%0d region=%0d, got x=%0d y=%0d z=%0d region=%0d",
              e.x, e.y, e.z, e.rg, $signed(m_tdata[31:0]), $signed(m_tdata[63:32]),
              $signed(m_tdata[95:64]), m_tuser);
        end
      end
    end
  end

  task automatic test_reset_registers();
    // both registers are zero: only the origin-centered degenerate face exists
    send_ray(0, 0, 0, 256, 0, 0);
    send_ray(100, -50, 0, 0, 0, 1);
    send_ray(-300, 0, -20, 1, 1, 1);
  endtask

  task automatic test_special_cases();
    no_idle = 1'b1;
    send_ray(0, 0, 100, 0, 0, 0);                   // zero direction: no hit
    send_ray(10, 20, 30, 5, -7, 0);                 // zero dz: barrel only
    send_ray(50, -40, 0, 0, 0, 3);                  // point z zero, straight along z
    send_ray(-50, 40, -9000, 0, 0, -3);             // negative z side endcap
    send_ray(9000, 9000, 0, 1, 0, 0);               // point inside the barrel: discriminant positive
    send_ray(2560, 0, 0, 0, 1, 0);                  // line along y, inside the barrel
    send_ray(0, 0, 10, 0, 5, 1);                    // dx zero, dy positive
    send_ray(0, 0, 10, 0, -5, 1);                   // dx zero, dy negative
    send_ray(0, 0, 0, -7, 3, 2);                    // negative dx
    send_ray(100, 100, 100, 1, 1, 1);               // diagonal direction: barrel nearer than endcap
    no_idle = 1'b0;
    send_ray(32'sh7fffffff, 32'sh7fffffff, 32'sh7fffffff,
             32'sh7fffffff, 32'sh7fffffff, 32'sh7fffffff);
    send_ray(-32'sh80000000, -32'sh80000000, -32'sh80000000,
             -32'sh80000000, -32'sh80000000, -32'sh80000000);
    send_ray(32'sh7fffffff, -32'sh80000000, 0, -32'sh80000000, 32'sh7fffffff, 1);
    send_ray(0, 0, 0, 1, 0, 32'sh7fffffff);
    send_ray(-1, -1, -1, -1, -1, -1);
  endtask

  task automatic test_random_geometry(input int count, input int unsigned span);
    logic signed [31:0] v[6];
    for (int i = 0; i < count; i++) begin
      if ((i % 50) < 10) no_idle = 1'b1;
      else no_idle = 1'b0;
      for (int k = 0; k < 6; k++) v[k] = coord_near(span);
      if ($urandom_range(0, 9) == 0) v[5] = 0;
      if ($urandom_range(0, 9) == 0) begin
        v[3] = 0; v[4] = 0;
      end
      send_ray(v[0], v[1], v[2], v[3], v[4], v[5]);
    end
    no_idle = 1'b0;
  endtask

  task automatic test_full_range(input int count);
    for (int i = 0; i < count; i++)
      send_ray($urandom, $urandom, $urandom, $urandom, $urandom, $urandom);
  endtask

  initial begin
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_reset_registers();
    drain_and_set(31'd256000, 31'd512000);
    test_special_cases();
    test_random_geometry(150, 600000);
    drain_and_set(CFG_MAX, CFG_MAX);
    test_special_cases();
    test_full_range(60);
    drain_and_set(31'd1, 31'd0);
    test_random_geometry(60, 8);
    drain_and_set(31'($urandom_range(1, 32'h7fffffff)), 31'($urandom_range(1, 32'h7fffffff)));
    test_full_range(40);
    test_random_geometry(40, 32'h7fffffff);
    drain_and_set(31'($urandom_range(1000, 100000)), 31'($urandom_range(1000, 100000)));
    test_random_geometry(100, 300000);
    s_tvalid <= 1'b0;
    while (expected_hits.size() > 0) @(posedge clk);
    repeat (LAT + 20) @(posedge clk);
    if (mismatches == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule

`default_nettype wire
